### hdl/fcc_pkg.sv
// shared types, constants and helpers of the frustum cube cull block
package fcc_pkg;

	// number of frustum planes and configuration index width
	localparam int PLANE_CNT = 6;
	localparam int CFG_IDX_W = 3;
	localparam int PLANE_W   = 64;

	// field widths
	localparam int COEF_W   = 16;
	localparam int SIZE_W   = 15;
	localparam int PROD_W   = 32;
	localparam int ABS_W    = 17;
	localparam int ABSSUM_W = 18;
	localparam int REACH_W  = 33;
	localparam int DSH_W    = 24;
	localparam int SUM_W    = 36;
	localparam int IN_W     = 64;
	localparam int OUT_W    = 8;

	// per-axis side codes
	localparam logic [1:0] SIDE_BOTH  = 2'b00;
	localparam logic [1:0] SIDE_FIRST = 2'b01;
	localparam logic [1:0] SIDE_OTHER = 2'b11;

	// item as it travels down the chain of cells
	typedef struct packed {
		logic signed [COEF_W-1:0] x;
		logic signed [COEF_W-1:0] y;
		logic signed [COEF_W-1:0] z;
		logic [SIZE_W-1:0]        half;
		logic                     vis;
		logic [PLANE_CNT-1:0]     pos;
	} item_t;

	// configuration write seen by every cell
	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [PLANE_W-1:0]   data;
	} cfg_wr_t;

	// magnitude of a signed coefficient
	function automatic logic [ABS_W-1:0] abs_coef(input logic signed [COEF_W-1:0] v);
		logic signed [ABS_W-1:0] ext;
		ext = ABS_W'(v);
		if (v < 0) begin
			return ABS_W'(-ext);
		end
		return ABS_W'(ext);
	endfunction

	// center classification against a plane pair
	function automatic logic [1:0] side_code(input logic first, input logic second);
		if (first && second) begin
			return SIDE_BOTH;
		end else if (first) begin
			return SIDE_FIRST;
		end
		return SIDE_OTHER;
	endfunction

endpackage

### hdl/fcc_cell.sv
// one plane cell: holds a plane and tests each passing item against it
module fcc_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  fcc_pkg::cfg_wr_t cfg,
	input  logic            in_valid,
	input  fcc_pkg::item_t  in_item,
	output logic            out_valid,
	output fcc_pkg::item_t  out_item
);
	import fcc_pkg::*;

	logic [PLANE_W-1:0] plane_q;

	logic signed [COEF_W-1:0] coef_a;
	logic signed [COEF_W-1:0] coef_b;
	logic signed [COEF_W-1:0] coef_c;
	logic signed [COEF_W-1:0] coef_d;
	logic [ABSSUM_W-1:0]      abs_sum;

	logic                     valid_s1, valid_s2, valid_s3;
	item_t                    item_s1, item_s2, item_s3;
	item_t                    item_nx;
	logic signed [PROD_W-1:0] prod_a_s1, prod_b_s1, prod_c_s1;
	logic [REACH_W-1:0]       reach_s1;
	logic signed [DSH_W-1:0]  dsh_s1;
	logic signed [SUM_W-1:0]  pa_s2, pb_s2, pc_s2;
	logic signed [SUM_W-1:0]  value;
	logic signed [SUM_W-1:0]  full;

	// plane register, written by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg.we && cfg.index == CFG_IDX_W'(IDX)) begin
			plane_q <= cfg.data;
		end
	end

	// coefficient unpacking and sum of magnitudes
	always_comb begin
		coef_a  = $signed(plane_q[15:0]);
		coef_b  = $signed(plane_q[31:16]);
		coef_c  = $signed(plane_q[47:32]);
		coef_d  = $signed(plane_q[63:48]);
		abs_sum = ABSSUM_W'(abs_coef(coef_a)) + ABSSUM_W'(abs_coef(coef_b))
			+ ABSSUM_W'(abs_coef(coef_c));
	end

	// final sums: center value and best corner value
	always_comb begin
		value = pa_s2 + pb_s2;
		full  = pa_s2 + pc_s2;
	end

	// item leaving the compare stage with this plane's outcome merged in
	always_comb begin
		item_nx          = item_s2;
		item_nx.vis      = item_s2.vis & (full > 0);
		item_nx.pos[IDX] = (value > 0);
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage payload: products, partial sums, compare
	always_ff @(posedge clk) begin
		if (en) begin
			item_s1   <= in_item;
			prod_a_s1 <= coef_a * in_item.x;
			prod_b_s1 <= coef_b * in_item.y;
			prod_c_s1 <= coef_c * in_item.z;
			reach_s1  <= REACH_W'(in_item.half) * REACH_W'(abs_sum);
			dsh_s1    <= $signed({coef_d, 8'h00});

			item_s2 <= item_s1;
			pa_s2   <= SUM_W'(prod_a_s1) + SUM_W'(prod_b_s1);
			pb_s2   <= SUM_W'(prod_c_s1) + SUM_W'(dsh_s1);
			pc_s2   <= SUM_W'(prod_c_s1) + SUM_W'(dsh_s1) + $signed(SUM_W'(reach_s1));

			item_s3 <= item_nx;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

### hdl/fcc_skid.sv
// output register with one skid entry between the cell chain and the receiver
module fcc_skid #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_data
);
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              skid_valid_q;
	logic [DATA_W-1:0] skid_data_q;
	logic              take;

	assign take     = out_valid_q && out_ready;
	assign in_ready = !skid_valid_q;

	// control: drain skid first, else route the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (in_valid) begin
			if (!out_valid_q || take) begin
				out_data_q <= in_data;
			end else begin
				skid_data_q <= in_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### hdl/frustum_cube_cull.sv
// top level of the frustum cube cull block: chain of six plane cells
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata, one cube each: center x, y, z
//   (signed Q8.8) and half size (unsigned Q7.8). Results leave on m_tvalid/
//   m_tready/m_tdata: visible flag and three side codes of the center.
//   Planes are loaded over cfg_valid/cfg_ready/cfg_index/cfg_data, index 0..5 for
//   left, right, down, up, near, far; higher indexes are ignored. cfg_ready is
//   always high; load planes only while no items are in flight.
//   Each item walks through six cells, one per plane, three stages per cell
//   (products, partial sums, compare), and then the output register, before its
//   result appears on m_tvalid. One item is taken every cycle while the receiver
//   keeps up.
//   When m_tready is low the result holds in the output register and one more
//   item moves into a skid entry; then s_tready falls and the whole chain stalls
//   until the receiver takes a result.
//   Reset clears all planes to zero, which rejects every cube, and empties the
//   pipeline and output registers.
module frustum_cube_cull (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// center_x [15:0], center_y [31:16], center_z [47:32], half_size [62:48], pad
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// visible [0], side_x [2:1], side_y [4:3], side_z [6:5], pad
	output logic [7:0]  m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import fcc_pkg::*;

	logic                 en;
	cfg_wr_t              cfg;
	logic                 chain_valid [PLANE_CNT+1];
	item_t                chain_item  [PLANE_CNT+1];
	item_t                last_item;
	logic [OUT_W-1:0]     result;

	assign cfg_ready = 1'b1;
	assign cfg.we    = cfg_valid && cfg_ready;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	assign s_tready = en;

	// unpack incoming item
	always_comb begin
		chain_valid[0]     = s_tvalid;
		chain_item[0].x    = $signed(s_tdata[15:0]);
		chain_item[0].y    = $signed(s_tdata[31:16]);
		chain_item[0].z    = $signed(s_tdata[47:32]);
		chain_item[0].half = s_tdata[62:48];
		chain_item[0].vis  = 1'b1;
		chain_item[0].pos  = '0;
	end

	// one cell per plane
	for (genvar g = 0; g < PLANE_CNT; g++) begin : g_cell
		fcc_cell #(
			.IDX(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.cfg      (cfg),
			.in_valid (chain_valid[g]),
			.in_item  (chain_item[g]),
			.out_valid(chain_valid[g+1]),
			.out_item (chain_item[g+1])
		);
	end

	// pack result
	always_comb begin
		last_item = chain_item[PLANE_CNT];
		result    = {1'b0,
			side_code(last_item.pos[4], last_item.pos[5]),
			side_code(last_item.pos[2], last_item.pos[3]),
			side_code(last_item.pos[0], last_item.pos[1]),
			last_item.vis};
	end

	fcc_skid #(
		.DATA_W(OUT_W)
	) u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_valid[PLANE_CNT]),
		.in_ready (en),
		.in_data  (result),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata)
	);

endmodule

### hdl/fcc_checker.sv
// port checker for the frustum cube cull block, bound to the top level
module fcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its bits
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// input side only backs off after the receiver stalled
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

	// side codes are never the unused code and padding is zero
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:1] != 2'b10 && m_tdata[4:3] != 2'b10
			&& m_tdata[6:5] != 2'b10 && !m_tdata[7])
		else $error("bad side code in result");

endmodule

bind frustum_cube_cull fcc_checker u_fcc_checker (.*);
